// File: rtl/core/blr_pkg.sv
// shared types and constants for the line rasterizer
package blr_pkg;

   // request opcodes
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // packed width of one decoded command for a given coordinate width
   // command, x, y, major end, error, two increments, three flags
   function automatic int cmd_bits(input int coord_bits);
      return 1 + 3 * coord_bits + (coord_bits + 3) + (coord_bits + 2)
         + (coord_bits + 3) + 3;
   endfunction

endpackage

// File: rtl/core/blr_req_if.sv
// request channel: command and line endpoints
interface blr_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (
      output valid, command, start_x, start_y, end_x, end_y,
      input  ready
   );

   modport sink (
      input  valid, command, start_x, start_y, end_x, end_y,
      output ready
   );
endinterface

// File: rtl/core/blr_rsp_if.sv
// response channel: one response per request, a pixel or the no-line flag
interface blr_rsp_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_pixel;
   logic                  no_line;

   modport source (
      output valid, pixel_x, pixel_y, last_pixel, no_line,
      input  ready
   );

   modport sink (
      input  valid, pixel_x, pixel_y, last_pixel, no_line,
      output ready
   );
endinterface

// File: rtl/core/blr_queue.sv
// small register queue between the decode front and the pixel back end
module blr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   // occupancy never exceeds the storage
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   // a lone write grows the queue by one entry
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a write");

   // reads only come from a queue that holds something
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("read from empty queue");

endmodule

// File: rtl/core/blr_front.sv
// decode front: classifies requests and does the line setup for starts
module blr_front #(
   parameter int  COORD_BITS = 12,
   localparam int CMD_W      = blr_pkg::cmd_bits(COORD_BITS)
) (
   blr_req_if.sink          req_if,
   input  logic             full,
   output logic             push,
   output logic [CMD_W-1:0] push_data
);
   localparam int CB = COORD_BITS;

   typedef struct packed {
      blr_pkg::cmd_type     command;
      logic [CB-1:0]        pos_x;
      logic [CB-1:0]        pos_y;
      logic [CB-1:0]        major_end;
      logic signed [CB+2:0] error_term;
      logic [CB+1:0]        inc_no_step;
      logic signed [CB+2:0] inc_with_step;
      logic                 minor_down;
      logic                 y_is_major;
      logic                 line_active;
   } cmd_entry_type;

   cmd_entry_type entry;
   logic [CB-1:0] adx, ady, amaj, amin;
   logic [CB-1:0] sx, sy, ex, ey;
   logic          y_major, swap;

   always_comb begin
      adx = (req_if.end_x >= req_if.start_x) ? req_if.end_x - req_if.start_x
                                             : req_if.start_x - req_if.end_x;
      ady = (req_if.end_y >= req_if.start_y) ? req_if.end_y - req_if.start_y
                                             : req_if.start_y - req_if.end_y;
      // ties walk along x
      y_major = (ady > adx);
      swap = y_major ? (req_if.start_y > req_if.end_y)
                     : (req_if.start_x > req_if.end_x);
      sx = swap ? req_if.end_x : req_if.start_x;
      sy = swap ? req_if.end_y : req_if.start_y;
      ex = swap ? req_if.start_x : req_if.end_x;
      ey = swap ? req_if.start_y : req_if.end_y;
      amaj = y_major ? ady : adx;
      amin = y_major ? adx : ady;

      entry.command       = blr_pkg::cmd_type'(req_if.command);
      entry.pos_x         = sx;
      entry.pos_y         = sy;
      entry.major_end     = y_major ? ey : ex;
      entry.error_term    = signed'({2'b00, amin, 1'b0}) - signed'({3'b000, amaj});
      entry.inc_no_step   = {1'b0, amin, 1'b0};
      entry.inc_with_step = signed'({2'b00, amin, 1'b0})
                          - signed'({2'b00, amaj, 1'b0});
      entry.minor_down    = y_major ? !(sx < ex) : !(sy < ey);
      entry.y_is_major    = y_major;
      entry.line_active   = (amaj != '0);
   end

   assign req_if.ready = !full;
   assign push         = req_if.valid && !full;
   assign push_data    = entry;

endmodule

// File: rtl/core/blr_back.sv
// pixel back end: line state, one step per cycle while the response is not held, response register
module blr_back #(
   parameter int  COORD_BITS = 12,
   localparam int CMD_W      = blr_pkg::cmd_bits(COORD_BITS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   input  logic [CMD_W-1:0] pop_data,
   output logic             pop,
   blr_rsp_if.source        rsp_if
);
   localparam int CB = COORD_BITS;

   typedef struct packed {
      blr_pkg::cmd_type     command;
      logic [CB-1:0]        pos_x;
      logic [CB-1:0]        pos_y;
      logic [CB-1:0]        major_end;
      logic signed [CB+2:0] error_term;
      logic [CB+1:0]        inc_no_step;
      logic signed [CB+2:0] inc_with_step;
      logic                 minor_down;
      logic                 y_is_major;
      logic                 line_active;
   } cmd_entry_type;

   cmd_entry_type entry;

   logic [CB-1:0]        cur_x_ff, cur_x_in;
   logic [CB-1:0]        cur_y_ff, cur_y_in;
   logic [CB-1:0]        major_end_ff, major_end_in;
   logic signed [CB+2:0] error_ff, error_in;
   logic [CB+1:0]        inc_no_ff, inc_no_in;
   logic signed [CB+2:0] inc_with_ff, inc_with_in;
   logic                 minor_down_ff, minor_down_in;
   logic                 y_major_ff, y_major_in;
   logic                 active_ff, active_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]        pixel_x_ff, pixel_x_in;
   logic [CB-1:0]        pixel_y_ff, pixel_y_in;
   logic                 last_ff, last_in;
   logic                 no_line_ff, no_line_in;

   logic [CB-1:0]        maj_cur, min_cur, maj_next, min_next;
   logic                 move_minor;
   logic signed [CB+2:0] err_step;

   always_comb begin
      entry = cmd_entry_type'(pop_data);
      pop   = pop_valid && (!rsp_valid_ff || rsp_if.ready);

      maj_cur    = y_major_ff ? cur_y_ff : cur_x_ff;
      min_cur    = y_major_ff ? cur_x_ff : cur_y_ff;
      move_minor = !error_ff[CB+2];
      maj_next   = maj_cur + 1'b1;
      if (move_minor) begin
         min_next = minor_down_ff ? min_cur - 1'b1 : min_cur + 1'b1;
         err_step = error_ff + inc_with_ff;
      end else begin
         min_next = min_cur;
         err_step = error_ff + signed'({1'b0, inc_no_ff});
      end

      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      major_end_in  = major_end_ff;
      error_in      = error_ff;
      inc_no_in     = inc_no_ff;
      inc_with_in   = inc_with_ff;
      minor_down_in = minor_down_ff;
      y_major_in    = y_major_ff;
      active_in     = active_ff;
      pixel_x_in    = pixel_x_ff;
      pixel_y_in    = pixel_y_ff;
      last_in       = last_ff;
      no_line_in    = no_line_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      if (pop) begin
         rsp_valid_in = 1'b1;
         unique case (entry.command)
            blr_pkg::CMD_START: begin
               cur_x_in      = entry.pos_x;
               cur_y_in      = entry.pos_y;
               major_end_in  = entry.major_end;
               error_in      = entry.error_term;
               inc_no_in     = entry.inc_no_step;
               inc_with_in   = entry.inc_with_step;
               minor_down_in = entry.minor_down;
               y_major_in    = entry.y_is_major;
               active_in     = entry.line_active;
               pixel_x_in    = entry.pos_x;
               pixel_y_in    = entry.pos_y;
               last_in       = !entry.line_active;
               no_line_in    = 1'b0;
            end
            blr_pkg::CMD_STEP: begin
               if (!active_ff) begin
                  pixel_x_in = '0;
                  pixel_y_in = '0;
                  last_in    = 1'b0;
                  no_line_in = 1'b1;
               end else begin
                  cur_x_in   = y_major_ff ? min_next : maj_next;
                  cur_y_in   = y_major_ff ? maj_next : min_next;
                  error_in   = err_step;
                  active_in  = (maj_next != major_end_ff);
                  pixel_x_in = y_major_ff ? min_next : maj_next;
                  pixel_y_in = y_major_ff ? maj_next : min_next;
                  last_in    = (maj_next == major_end_ff);
                  no_line_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      major_end_ff  <= major_end_in;
      error_ff      <= error_in;
      inc_no_ff     <= inc_no_in;
      inc_with_ff   <= inc_with_in;
      minor_down_ff <= minor_down_in;
      y_major_ff    <= y_major_in;
      pixel_x_ff    <= pixel_x_in;
      pixel_y_ff    <= pixel_y_in;
      last_ff       <= last_in;
      no_line_ff    <= no_line_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_x    = pixel_x_ff;
   assign rsp_if.pixel_y    = pixel_y_ff;
   assign rsp_if.last_pixel = last_ff;
   assign rsp_if.no_line    = no_line_ff;

   // shown pixel and line state agree: last pixel exactly when the line closed
   a_last_matches_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !no_line_ff) |-> (last_ff == !active_ff))
      else $error("last pixel flag out of step with line state");

   // an active line has not yet reached its end on the major axis
   a_major_below_end: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (maj_cur < major_end_ff))
      else $error("major coordinate past line end");

   // a no-line response carries a zero pixel
   a_no_line_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && no_line_ff) |->
         (pixel_x_ff == '0 && pixel_y_ff == '0 && !last_ff))
      else $error("no-line response with pixel data");

endmodule

// File: rtl/core/bresenham_line_rasterizer.sv
// an accepted request is written into the queue, then its pixel is registered in the response register
// throughput: one request and one pixel per clock while responses are taken; the step is one add and compare
// the two-entry queue between decode and step logic lets either side stall alone
// reset (synchronous, active high) empties the queue, drops any line, clears response valid
// a step request with no line active answers with the no-line flag
module bresenham_line_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   blr_req_if.sink   req_if,
   blr_rsp_if.source rsp_if
);
   localparam int CMD_W = blr_pkg::cmd_bits(COORD_BITS);

   // front to queue
   logic             push;
   logic [CMD_W-1:0] push_data;
   logic             full;

   // queue to back end
   logic             pop;
   logic             pop_valid;
   logic [CMD_W-1:0] pop_data;

   // decode front: abs deltas, major axis pick, endpoint order, error setup
   blr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_if    (req_if),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   // decoded requests wait here until the back end can take them
   blr_queue #(
      .WIDTH (CMD_W),
      .DEPTH (blr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // back end: holds the line, walks one pixel per step, owns response register
   blr_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule
